/* design/slr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch lap recorder package
// Event codes, fixed field widths and the control group that travels from
// the timekeeper to the lap store.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int CMD_W       = 2;
    localparam int OFFSET_W    = 3;
    localparam int HUND_W      = 7;
    localparam int OUT_SEC_W   = 16;
    localparam int TICK_W      = 7;
    localparam int HUND_PER_S  = 100;
    localparam int PROD_W      = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_BTN_UP   = 2'd1,
        CMD_BTN_DOWN = 2'd2,
        CMD_READ     = 2'd3
    } slr_cmd_t;

    typedef struct packed {
        logic acc;
        logic wr;
        logic clr;
        logic rd;
    } slr_mem_ctl_t;

endpackage

`default_nettype wire

/* design/slr_evt_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Event channel
// Carries one stopwatch event per transaction under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slr_evt_if;

    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] lap_offset;

    modport source (output valid, output cmd, output lap_offset, input ready);
    modport sink   (input valid, input cmd, input lap_offset, output ready);

endinterface

`default_nettype wire

/* design/slr_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Carries the stopwatch status and the selected lap, one per transaction.
// ----------------------------------------------------------------------------
interface slr_res_if;

    logic        valid;
    logic        ready;
    logic        running;
    logic [6:0]  cur_hundredths;
    logic [15:0] cur_seconds;
    logic [6:0]  lap_hundredths;
    logic [15:0] lap_seconds;

    modport source (
        output valid, output running, output cur_hundredths, output cur_seconds,
        output lap_hundredths, output lap_seconds, input ready
    );
    modport sink (
        input valid, input running, input cur_hundredths, input cur_seconds,
        input lap_hundredths, input lap_seconds, output ready
    );

endinterface

`default_nettype wire

/* design/slr_timekeeper.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch timekeeper
// Holds run state, tick count, current time, the lap ring head and the
// control-enable register, and issues one lap store operation per event.
// ----------------------------------------------------------------------------
module slr_timekeeper
    import slr_pkg::*;
#(
    parameter int LAP_DEPTH    = 5,
    parameter int SECONDS_BITS = 16,
    parameter int ADDR_W       = 3
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [CMD_W-1:0]        cmd,
    input  wire logic [OFFSET_W-1:0]     lap_offset,
    input  wire logic                    cfg_wr_en,
    input  wire logic                    cfg_wr_data,
    output logic                         running,
    output logic [HUND_W-1:0]            hundredths,
    output logic [SECONDS_BITS-1:0]      seconds,
    output slr_mem_ctl_t                 mem_ctl,
    output logic [ADDR_W-1:0]            mem_addr
);

    localparam logic [ADDR_W-1:0] HEAD_LAST = ADDR_W'(LAP_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(LAP_DEPTH);

    logic                    ctrl_en_reg;
    logic                    run_reg, run_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [HUND_W-1:0]       hund_reg, hund_next;
    logic [SECONDS_BITS-1:0] sec_reg, sec_next;
    logic [ADDR_W-1:0]       head_reg, head_next;

    logic [ADDR_W-1:0]       off_wrap [8];
    logic [TICK_W:0]         tick_inc;
    logic [PROD_W-1:0]       hund_prod;
    logic [ADDR_W:0]         slot_sum;
    logic [ADDR_W-1:0]       read_slot;

    for (genvar i = 0; i < 8; i++) begin : g_off_wrap
        assign off_wrap[i] = ADDR_W'(i % LAP_DEPTH);
    end

    assign tick_inc  = {1'b0, tick_reg} + (TICK_W + 1)'(1);
    assign hund_prod = PROD_W'(tick_inc[TICK_W-1:0]) * PROD_W'(HUND_PER_S);
    assign slot_sum  = {1'b0, head_reg} + {1'b0, off_wrap[lap_offset]};
    assign read_slot = (slot_sum >= DEPTH_EXT) ? ADDR_W'(slot_sum - DEPTH_EXT)
                                               : slot_sum[ADDR_W-1:0];

    always_comb
    begin
        run_next  = run_reg;
        tick_next = tick_reg;
        hund_next = hund_reg;
        sec_next  = sec_reg;
        head_next = head_reg;
        mem_ctl   = '0;
        mem_addr  = head_reg;
        if (accept)
        begin
            mem_ctl.acc = 1'b1;
            unique case (slr_cmd_t'(cmd))
                CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        if (tick_inc[TICK_W])
                        begin
                            tick_next = '0;
                            hund_next = '0;
                            sec_next  = sec_reg + SECONDS_BITS'(1);
                        end
                        else
                        begin
                            tick_next = tick_inc[TICK_W-1:0];
                            hund_next = hund_prod[PROD_W-1:TICK_W];
                        end
                    end
                end
                CMD_BTN_UP:
                begin
                    if (ctrl_en_reg)
                    begin
                        run_next = !run_reg;
                    end
                end
                CMD_BTN_DOWN:
                begin
                    if (ctrl_en_reg)
                    begin
                        if (run_reg)
                        begin
                            head_next  = (head_reg == '0) ? HEAD_LAST
                                                          : head_reg - ADDR_W'(1);
                            mem_ctl.wr = 1'b1;
                            mem_addr   = head_next;
                        end
                        else
                        begin
                            tick_next   = '0;
                            hund_next   = '0;
                            sec_next    = '0;
                            head_next   = '0;
                            mem_ctl.clr = 1'b1;
                        end
                    end
                end
                CMD_READ:
                begin
                    mem_ctl.rd = 1'b1;
                    mem_addr   = read_slot;
                end
                default:
                begin
                    mem_ctl.rd = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_en_reg <= 1'b1;
            run_reg     <= 1'b0;
            tick_reg    <= '0;
            hund_reg    <= '0;
            sec_reg     <= '0;
            head_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ctrl_en_reg <= cfg_wr_data;
            end
            run_reg  <= run_next;
            tick_reg <= tick_next;
            hund_reg <= hund_next;
            sec_reg  <= sec_next;
            head_reg <= head_next;
        end
    end

    assign running    = run_reg;
    assign hundredths = hund_reg;
    assign seconds    = sec_reg;

endmodule

`default_nettype wire

/* design/slr_lap_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Lap store
// Ring of lap entries with one write or one registered read per event and a
// valid bit per entry so that a clear takes effect at once.
// ----------------------------------------------------------------------------
module slr_lap_store
    import slr_pkg::*;
#(
    parameter int LAP_DEPTH = 5,
    parameter int DATA_W    = 23,
    parameter int ADDR_W    = 3
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slr_mem_ctl_t      mem_ctl,
    input  wire logic [ADDR_W-1:0] mem_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0]      rd_data,
    output logic                   rd_hit
);

    logic [DATA_W-1:0]    mem [LAP_DEPTH];
    logic [LAP_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr)
        begin
            mem[mem_addr] <= wr_data;
        end
        if (mem_ctl.rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (mem_ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (mem_ctl.wr)
            begin
                valid_reg[mem_addr] <= 1'b1;
            end
            if (mem_ctl.acc)
            begin
                rd_hit_reg <= mem_ctl.rd && valid_reg[mem_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

`default_nettype wire

/* design/stopwatch_lap_recorder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stopwatch lap recorder core
// Event-driven stopwatch with a ring of recorded laps, one result per event.
//
//   channel  dir  handshake        payload
//   evt      in   valid / ready    cmd, lap_offset
//   res      out  valid / ready    running, cur_*, lap_*
//   cfg      in   cfg_wr_en        cfg_wr_data (control enable)
//
// Each event updates the state at the edge it is accepted and its result is
// registered at the output; one event is accepted every cycle unless stalled.
// The lap read goes through the registered read port of the lap store.
// Reset leaves the watch stopped at zero with every lap entry reading zero.
// While a result is held at the output, one more event is taken in; after
// that the input stalls until the output transaction completes.
// ----------------------------------------------------------------------------
module stopwatch_lap_recorder_core
    import slr_pkg::*;
#(
    parameter int LAP_DEPTH    = 5,
    parameter int SECONDS_BITS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    slr_evt_if.sink     evt,
    slr_res_if.source   res,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data
);

    localparam int ADDR_W = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
    localparam int DATA_W = HUND_W + SECONDS_BITS;

    logic                    evt_accept;
    logic                    out_move;
    logic                    running;
    logic [HUND_W-1:0]       hundredths;
    logic [SECONDS_BITS-1:0] seconds;
    slr_mem_ctl_t            mem_ctl;
    logic [ADDR_W-1:0]       mem_addr;
    logic [DATA_W-1:0]       rd_data;
    logic                    rd_hit;
    logic [31:0]             cur_sec_ext;
    logic [31:0]             lap_sec_ext;

    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    running_reg;
    logic [HUND_W-1:0]       cur_hund_reg;
    logic [OUT_SEC_W-1:0]    cur_sec_reg;
    logic [HUND_W-1:0]       lap_hund_reg;
    logic [OUT_SEC_W-1:0]    lap_sec_reg;

    slr_timekeeper #(
        .LAP_DEPTH    (LAP_DEPTH),
        .SECONDS_BITS (SECONDS_BITS),
        .ADDR_W       (ADDR_W)
    ) u_timekeeper (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (evt_accept),
        .cmd         (evt.cmd),
        .lap_offset  (evt.lap_offset),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .running     (running),
        .hundredths  (hundredths),
        .seconds     (seconds),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr)
    );

    slr_lap_store #(
        .LAP_DEPTH (LAP_DEPTH),
        .DATA_W    (DATA_W),
        .ADDR_W    (ADDR_W)
    ) u_lap_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .wr_data  ({hundredths, seconds}),
        .rd_data  (rd_data),
        .rd_hit   (rd_hit)
    );

    assign out_move   = pend_reg && (!out_valid_reg || res.ready);
    assign evt.ready  = !pend_reg || !out_valid_reg || res.ready;
    assign evt_accept = evt.valid && evt.ready;

    assign cur_sec_ext = 32'(seconds);
    assign lap_sec_ext = 32'(rd_data[SECONDS_BITS-1:0]);

    always_comb
    begin
        pend_next      = evt_accept ? 1'b1 : (out_move ? 1'b0 : pend_reg);
        out_valid_next = out_move ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move)
        begin
            running_reg  <= running;
            cur_hund_reg <= hundredths;
            cur_sec_reg  <= cur_sec_ext[OUT_SEC_W-1:0];
            lap_hund_reg <= rd_hit ? rd_data[DATA_W-1:SECONDS_BITS] : '0;
            lap_sec_reg  <= rd_hit ? lap_sec_ext[OUT_SEC_W-1:0] : '0;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.running        = running_reg;
    assign res.cur_hundredths = cur_hund_reg;
    assign res.cur_seconds    = cur_sec_reg;
    assign res.lap_hundredths = lap_hund_reg;
    assign res.lap_seconds    = lap_sec_reg;

    a_hund_range: assert property (@(posedge clk) disable iff (!rst_n)
        hundredths < HUND_W'(HUND_PER_S))
        else $error("Current hundredths left the range of one second.");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && out_valid_reg && !res.ready) |-> !evt.ready)
        else $error("An event was offered a slot while the pipeline was full.");

    a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_accept && evt.cmd == CMD_TICK && !running) |=> $stable(seconds))
        else $error("A tick changed the time while the stopwatch was stopped.");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stopwatch lap recorder testbench
// Drives an event table, then about a thousand random events into the core,
// the channels idling at random before the last phase. Every event is run
// through a software stopwatch that keeps its own laps. Each returned
// status is compared field by field with the oldest prediction. The control
// enable is changed only after every pending status has come back.
// ----------------------------------------------------------------------------
module testbench;
    import slr_pkg::*;

    localparam int LAP_DEPTH        = 5;
    localparam int TICKS_PER_SECOND = 128;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int RANDOM_ON_ITEMS  = 300;
    localparam int RANDOM_OFF_ITEMS = 40;

    typedef struct packed {
        logic                 running;
        logic [HUND_W-1:0]    cur_hund;
        logic [OUT_SEC_W-1:0] cur_sec;
        logic [HUND_W-1:0]    lap_hund;
        logic [OUT_SEC_W-1:0] lap_sec;
    } watch_status_t;

    typedef struct {
        bit            is_cfg;
        bit            cfg_val;
        slr_cmd_t      op;
        logic [2:0]    off;
        bit            known;
        watch_status_t want;
    } drill_row_t;

    localparam watch_status_t AT_ZERO_STOPPED = '{1'b0, 7'd0, 16'd0, 7'd0, 16'd0};
    localparam watch_status_t AT_ZERO_RUNNING = '{1'b1, 7'd0, 16'd0, 7'd0, 16'd0};

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    slr_evt_if evt_ch ();
    slr_res_if res_ch ();

    stopwatch_lap_recorder_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bit                   sw_ctrl_en = 1'b1;
    bit                   sw_running = 1'b0;
    bit [TICK_W-1:0]      sw_ticks   = '0;
    bit [HUND_W-1:0]      sw_hund    = '0;
    bit [OUT_SEC_W-1:0]   sw_sec     = '0;
    int                   sw_head    = 0;
    bit [HUND_W-1:0]      sw_lap_hund [LAP_DEPTH];
    bit [OUT_SEC_W-1:0]   sw_lap_sec  [LAP_DEPTH];

    watch_status_t status_due [$];
    drill_row_t    drill [$];
    int            evt_gap_pct   = 0;
    int            res_stall_pct = 0;
    int            mismatches    = 0;
    int            quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic watch_status_t advance_watch(slr_cmd_t op, logic [2:0] off);
        watch_status_t s;
        int slot;
        int scaled;
        s = '0;
        case (op)
            CMD_TICK:
            begin
                if (sw_running)
                begin
                    if (int'(sw_ticks) + 1 >= TICKS_PER_SECOND)
                    begin
                        sw_ticks = '0;
                        sw_hund  = '0;
                        sw_sec   = sw_sec + 1'b1;
                    end
                    else
                    begin
                        sw_ticks = sw_ticks + 1'b1;
                        scaled   = (int'(sw_ticks) * HUND_PER_S) / TICKS_PER_SECOND;
                        sw_hund  = scaled[HUND_W-1:0];
                    end
                end
            end
            CMD_BTN_UP:
            begin
                if (sw_ctrl_en)
                    sw_running = !sw_running;
            end
            CMD_BTN_DOWN:
            begin
                if (sw_ctrl_en && sw_running)
                begin
                    sw_head = (sw_head == 0) ? LAP_DEPTH - 1 : sw_head - 1;
                    sw_lap_hund[sw_head] = sw_hund;
                    sw_lap_sec[sw_head]  = sw_sec;
                end
                else if (sw_ctrl_en)
                begin
                    sw_ticks = '0;
                    sw_hund  = '0;
                    sw_sec   = '0;
                    sw_head  = 0;
                    for (int i = 0; i < LAP_DEPTH; i++)
                    begin
                        sw_lap_hund[i] = '0;
                        sw_lap_sec[i]  = '0;
                    end
                end
            end
            default:
            begin
                slot       = (sw_head + int'(off)) % LAP_DEPTH;
                s.lap_hund = sw_lap_hund[slot];
                s.lap_sec  = sw_lap_sec[slot];
            end
        endcase
        s.running  = sw_running;
        s.cur_hund = sw_hund;
        s.cur_sec  = sw_sec;
        return s;
    endfunction

    function automatic slr_cmd_t pick_event();
        int roll;
        roll = $urandom_range(99);
        if (sw_running)
            return (roll < 70) ? CMD_TICK : (roll < 80) ? CMD_BTN_DOWN :
                   (roll < 98) ? CMD_READ : CMD_BTN_UP;
        return (roll < 30) ? CMD_BTN_UP : (roll < 70) ? CMD_READ :
               (roll < 92) ? CMD_TICK : CMD_BTN_DOWN;
    endfunction

    function automatic drill_row_t event_row(slr_cmd_t op, logic [2:0] off);
        drill_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = 1'b0;
        r.op      = op;
        r.off     = off;
        r.known   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic drill_row_t known_row(slr_cmd_t op, logic [2:0] off,
                                             watch_status_t want);
        drill_row_t r;
        r       = event_row(op, off);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic drill_row_t enable_row(bit en);
        drill_row_t r;
        r         = event_row(CMD_TICK, 3'd0);
        r.is_cfg  = 1'b1;
        r.cfg_val = en;
        return r;
    endfunction

    task automatic send_event(slr_cmd_t op, logic [2:0] off, bit known,
                              watch_status_t want);
        watch_status_t predicted;
        while ($urandom_range(99) < evt_gap_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.cmd        <= op;
        evt_ch.lap_offset <= off;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        predicted = advance_watch(op, off);
        status_due.push_back(known ? want : predicted);
    endtask

    task automatic settle();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_control(bit en);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sw_ctrl_en = en;
    endtask

    task automatic compare_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end

    always @(posedge clk)
    begin
        watch_status_t exp_s;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t: status with none expected, actual running %0d seconds %0d",
                         $time, res_ch.running, res_ch.cur_seconds);
                mismatches++;
            end
            else
            begin
                exp_s = status_due.pop_front();
                compare_field("running", exp_s.running, res_ch.running);
                compare_field("cur_hundredths", exp_s.cur_hund, res_ch.cur_hundredths);
                compare_field("cur_seconds", exp_s.cur_sec, res_ch.cur_seconds);
                compare_field("lap_hundredths", exp_s.lap_hund, res_ch.lap_hundredths);
                compare_field("lap_seconds", exp_s.lap_sec, res_ch.lap_seconds);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= 1'b0;
        evt_ch.valid      <= 1'b0;
        evt_ch.cmd        <= CMD_TICK;
        evt_ch.lap_offset <= 3'd0;
        for (int i = 0; i < LAP_DEPTH; i++)
        begin
            sw_lap_hund[i] = '0;
            sw_lap_sec[i]  = '0;
        end

        drill.push_back(known_row(CMD_READ, 3'd0, AT_ZERO_STOPPED));
        drill.push_back(known_row(CMD_READ, 3'd7, AT_ZERO_STOPPED));
        drill.push_back(known_row(CMD_TICK, 3'd0, AT_ZERO_STOPPED));
        drill.push_back(known_row(CMD_BTN_DOWN, 3'd0, AT_ZERO_STOPPED));
        drill.push_back(enable_row(1'b1));
        drill.push_back(known_row(CMD_BTN_UP, 3'd0, AT_ZERO_RUNNING));
        drill.push_back(event_row(CMD_TICK, 3'd0));
        drill.push_back(event_row(CMD_TICK, 3'd5));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_READ, 3'd0));
        drill.push_back(event_row(CMD_READ, 3'd4));
        drill.push_back(event_row(CMD_TICK, 3'd0));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_TICK, 3'd0));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_READ, 3'd5));
        drill.push_back(event_row(CMD_READ, 3'd6));
        drill.push_back(event_row(CMD_READ, 3'd2));
        drill.push_back(enable_row(1'b0));
        drill.push_back(event_row(CMD_BTN_UP, 3'd0));
        drill.push_back(event_row(CMD_BTN_DOWN, 3'd0));
        drill.push_back(event_row(CMD_TICK, 3'd0));
        drill.push_back(event_row(CMD_READ, 3'd1));
        drill.push_back(enable_row(1'b1));
        drill.push_back(event_row(CMD_BTN_UP, 3'd0));
        drill.push_back(known_row(CMD_BTN_DOWN, 3'd0, AT_ZERO_STOPPED));
        drill.push_back(known_row(CMD_READ, 3'd3, AT_ZERO_STOPPED));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        evt_gap_pct   = 14;
        res_stall_pct = 52;
        foreach (drill[i])
        begin
            if (drill[i].is_cfg)
                write_control(drill[i].cfg_val);
            else
                send_event(drill[i].op, drill[i].off, drill[i].known, drill[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            settle();
            evt_gap_pct   = (phase == 0) ? 14 : (phase == 1) ? 52 : 0;
            res_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 14 : 0;
            write_control(1'b1);
            repeat (RANDOM_ON_ITEMS)
                send_event(pick_event(), 3'($urandom_range(7)), 1'b0, '0);
            write_control(1'b0);
            repeat (RANDOM_OFF_ITEMS)
                send_event(pick_event(), 3'($urandom_range(7)), 1'b0, '0);
        end

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
